/* hw/rtl/fprm_pkg.sv */
// Package for the frame pacer and rate meter: event and mode codes, timing
// constants, and the request/status structs of the shared multiply/divide unit.
// No dependencies.
`default_nettype none
package fprm_pkg;

    // Event kinds carried in tuser
    localparam logic [1:0] KIND_VI = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_HK = 2'd2;

    // Pacing modes
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_DRAWN = 2'd2;

    // Register indexes
    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_MODE = 1'b1;

    localparam logic [19:0] PERIOD_RESET = 20'd16667;
    localparam logic [1:0] MODE_RESET = 2'd1;

    localparam logic [31:0] WINDOW_MIN_US = 32'd500000;
    localparam logic [31:0] STALE_US = 32'd1000000;
    localparam logic [31:0] WAIT_LIMIT_US = 32'd1000000;

    // 256000000 = 15625 << 14
    localparam logic [19:0] RATE_MUL = 20'd15625;
    localparam int RATE_SHIFT = 14;
    localparam logic [15:0] RATE_MAX = 16'hFFFF;

    // Shared unit sizing
    localparam int MDU_XW = 60;
    localparam int MDU_PW = 53;
    localparam logic [4:0] MUL_STEPS = 5'd20;
    localparam logic [4:0] DIV_STEPS = 5'd16;

    typedef struct packed {
        logic start;
        logic op_div;
    } t_mdu_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_mdu_stat;

endpackage
`default_nettype wire

/* hw/rtl/fprm_mdu.sv */
// Iterative multiply/divide unit: one shared 54-bit adder, shift-add multiply
// (20 steps) and restoring divide to a saturating 16-bit quotient (16 steps).
// Depends on fprm_pkg.
`default_nettype none
module fprm_mdu
    import fprm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mdu_req          i_req,
    input  wire logic [MDU_XW-1:0] i_x,
    input  wire logic [31:0]       i_y,
    output t_mdu_stat              o_stat,
    output logic [MDU_PW-1:0]      o_result
);

    logic              r_busy;
    logic              r_div;
    logic              r_done;
    logic              r_sat;
    logic [4:0]        r_step;
    logic [MDU_PW-1:0] r_acc;
    logic [MDU_PW-1:0] r_sh;
    logic [31:0]       r_b;

    logic [32:0]       div_t;
    logic [MDU_PW-1:0] add_a;
    logic [MDU_PW-1:0] add_b;
    logic              add_cin;
    logic [MDU_PW:0]   add_sum;
    logic              start_sat;

    // Divide step: shift in the next dividend bit, trial subtract via the adder
    assign div_t = {r_acc[31:0], r_sh[15]};

    always_comb begin
        if (r_div) begin
            add_a = {{(MDU_PW-33){1'b0}}, div_t};
            add_b = ~{{(MDU_PW-32){1'b0}}, r_b};
            add_cin = 1'b1;
        end else begin
            add_a = r_acc;
            add_b = r_sh;
            add_cin = 1'b0;
        end
        add_sum = {1'b0, add_a} + {1'b0, add_b} + {{MDU_PW{1'b0}}, add_cin};
    end

    // Quotient overflows 16 bits exactly when num / 2^16 >= den
    assign start_sat = (i_x[MDU_XW-1:16] >= {{(MDU_XW-48){1'b0}}, i_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_div <= 1'b0;
            r_sat <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_div <= i_req.op_div;
                r_sat <= 1'b0;
                if (i_req.op_div) begin
                    r_acc <= {{(MDU_PW-32){1'b0}}, i_x[47:16]};
                    r_sh <= {{(MDU_PW-16){1'b0}}, i_x[15:0]};
                    r_b <= i_y;
                    r_step <= DIV_STEPS;
                    if (start_sat) begin
                        r_sat <= 1'b1;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end else begin
                        r_busy <= 1'b1;
                    end
                end else begin
                    r_acc <= '0;
                    r_sh <= i_x[MDU_PW-1:0];
                    r_b <= {12'd0, i_y[19:0]};
                    r_step <= MUL_STEPS;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_div) begin
                    if (add_sum[MDU_PW]) begin
                        r_acc <= {{(MDU_PW-32){1'b0}}, add_sum[31:0]};
                    end else begin
                        r_acc <= {{(MDU_PW-32){1'b0}}, div_t[31:0]};
                    end
                    r_sh <= {r_sh[MDU_PW-2:0], add_sum[MDU_PW]};
                end else begin
                    if (r_b[0]) begin
                        r_acc <= add_sum[MDU_PW-1:0];
                    end
                    r_sh <= {r_sh[MDU_PW-2:0], 1'b0};
                    r_b <= {1'b0, r_b[31:1]};
                end
                r_step <= r_step - 5'd1;
                if (r_step == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.sat = r_sat;
    assign o_result = r_div ? {{(MDU_PW-16){1'b0}}, r_sh[15:0]} : r_acc;

endmodule
`default_nettype wire

/* hw/rtl/frame_pacer_rate_meter_core.sv */
// Top level of the frame pacer and rate meter: stream ports, APB registers,
// event sequencer and rate state. Depends on fprm_pkg and fprm_mdu.
//
// Usage:
//   Input stream: s_axis_tuser holds the event kind (0 video interrupt,
//   1 frame drawn, 2 housekeeping), s_axis_tdata the 32-bit microsecond time.
//   Output stream: one result per request, {frame_rate_q8, vi_rate_q8, wait_us}.
//   APB: register 0 (addr 0) is the 20-bit target period, register 1 (addr 4)
//   the 2-bit pacing mode; write only while the block is idle (not enforced).
// Timing:
//   One request at a time. s_axis_tready is high only in the idle state.
//   The time from one accepted request to the next is set by the shared unit:
//   a housekeeping tick or unused kind does not use it, an interrupt that
//   checks its pacing bound runs one multiply and a paced one a second, and
//   a closing window runs a multiply and a divide (the divide saturates
//   without stepping when the rate clips). The result becomes valid as the
//   block returns to idle.
// Reset:
//   Synchronous, active low; all rate state clears, registers take their
//   defaults (period 16667 us, mode 1), the output register empties.
// Stall:
//   The result waits in the output register; the block takes the next request
//   meanwhile and holds its own result until the register frees up.
`default_nettype none
module frame_pacer_rate_meter_core
    import fprm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] now_us
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [19:0] wait_us, [35:20] vi_rate_q8,
                                             // [51:36] frame_rate_q8, [55:52] zero
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_BOUND,
        S_TGT,
        S_PACE,
        S_WINDOW,
        S_NUM,
        S_DIV,
        S_COMMIT,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [19:0] r_period;
    logic [1:0]  r_mode;

    // rate and pacing state
    logic [31:0] r_vi_count;
    logic [31:0] r_vi_start;
    logic [31:0] r_vi_last;
    logic [31:0] r_vi_wait_cnt;
    logic [15:0] r_vi_rate;
    logic [31:0] r_fr_count;
    logic [31:0] r_fr_start;
    logic [31:0] r_fr_last;
    logic [15:0] r_fr_rate;
    logic        r_drawn;

    // per-request working registers
    logic [1:0]  r_kind;
    logic [31:0] r_now;
    logic [31:0] r_cnt;
    logic [31:0] r_start;
    logic [31:0] r_eff;
    logic [31:0] r_elapsed;
    logic [19:0] r_wait;
    logic [15:0] r_rate;
    logic        r_rate_upd;

    // shared unit request
    logic              r_mdu_start;
    logic              r_mdu_div;
    logic [MDU_XW-1:0] r_mdu_x;
    logic [31:0]       r_mdu_y;
    t_mdu_req          mdu_req;
    t_mdu_stat         mdu_stat;
    logic [MDU_PW-1:0] mdu_result;

    // output register
    logic        r_out_valid;
    logic [55:0] r_out_data;

    logic        cfg_wr;
    logic        in_fire;
    logic [31:0] vi_dif;
    logic [31:0] fr_dif;
    logic [31:0] target;
    logic [31:0] pace_d;
    logic [31:0] elapsed;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out_data;

    always_comb begin
        case (paddr[2])
            REG_PERIOD: prdata = {12'd0, r_period};
            REG_MODE:   prdata = {30'd0, r_mode};
            default:    prdata = '0;
        endcase
    end

    assign mdu_req.start = r_mdu_start;
    assign mdu_req.op_div = r_mdu_div;

    // Interval since the previous event of each channel, mod 2^32
    assign vi_dif = r_now - r_vi_last;
    assign fr_dif = r_now - r_fr_last;
    // Paced target: window start plus period times interrupt count (low 32 bits)
    assign target = r_start + mdu_result[31:0];
    assign pace_d = r_eff - r_now;
    assign elapsed = r_eff - r_start;

    fprm_mdu u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mdu_req),
        .i_x      (r_mdu_x),
        .i_y      (r_mdu_y),
        .o_stat   (mdu_stat),
        .o_result (mdu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_period <= PERIOD_RESET;
            r_mode <= MODE_RESET;
            r_vi_count <= '0;
            r_vi_start <= '0;
            r_vi_last <= '0;
            r_vi_wait_cnt <= '0;
            r_vi_rate <= '0;
            r_fr_count <= '0;
            r_fr_start <= '0;
            r_fr_last <= '0;
            r_fr_rate <= '0;
            r_drawn <= 1'b0;
            r_mdu_start <= 1'b0;
            r_mdu_div <= 1'b0;
            r_rate_upd <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    REG_PERIOD: r_period <= pwdata[19:0];
                    REG_MODE:   r_mode <= pwdata[1:0];
                    default:    r_period <= r_period;
                endcase
            end

            // Load a finished result; drop it once the receiver takes it
            if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_kind <= s_axis_tuser;
                        r_now <= s_axis_tdata;
                        r_wait <= '0;
                        r_rate_upd <= 1'b0;
                        r_state <= S_SETUP;
                    end
                end

                S_SETUP: begin
                    r_eff <= r_now;
                    case (r_kind)
                        KIND_VI: begin
                            r_cnt <= r_vi_count + 32'd1;
                            r_start <= r_vi_start;
                            if (r_mode == MODE_OFF) begin
                                r_state <= S_WINDOW;
                            end else if (r_mode == MODE_DRAWN && !r_drawn) begin
                                // Count a waited interrupt, no pacing
                                r_vi_wait_cnt <= r_vi_wait_cnt + 32'd1;
                                r_state <= S_WINDOW;
                            end else begin
                                // Launch bound = period * (wait count + 1)
                                r_mdu_start <= 1'b1;
                                r_mdu_div <= 1'b0;
                                r_mdu_x <= {{(MDU_XW-33){1'b0}},
                                            {1'b0, r_vi_wait_cnt} + 33'd1};
                                r_mdu_y <= {12'd0, r_period};
                                r_drawn <= 1'b0;
                                r_vi_wait_cnt <= '0;
                                r_state <= S_BOUND;
                            end
                        end
                        KIND_FRAME: begin
                            r_cnt <= r_fr_count + 32'd1;
                            r_start <= r_fr_start;
                            r_drawn <= 1'b1;
                            r_state <= S_WINDOW;
                        end
                        KIND_HK: begin
                            // Clear rates whose channel went quiet
                            if (fr_dif > STALE_US) begin
                                r_fr_rate <= '0;
                            end
                            if (vi_dif > STALE_US) begin
                                r_vi_rate <= '0;
                            end
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end

                S_BOUND: begin
                    if (mdu_stat.done) begin
                        if ({{(MDU_PW-32){1'b0}}, vi_dif} < mdu_result) begin
                            // Launch period * interrupt count for the target
                            r_mdu_start <= 1'b1;
                            r_mdu_div <= 1'b0;
                            r_mdu_x <= {{(MDU_XW-32){1'b0}}, r_cnt};
                            r_mdu_y <= {12'd0, r_period};
                            r_state <= S_TGT;
                        end else begin
                            r_mdu_start <= 1'b0;
                            r_state <= S_WINDOW;
                        end
                    end else begin
                        r_mdu_start <= 1'b0;
                    end
                end

                S_TGT: begin
                    r_mdu_start <= 1'b0;
                    if (mdu_stat.done) begin
                        r_eff <= target;
                        r_state <= S_PACE;
                    end
                end

                S_PACE: begin
                    // Report a wait only when the target is ahead and within reach
                    if (pace_d != 32'd0 && pace_d < WAIT_LIMIT_US) begin
                        r_wait <= pace_d[19:0];
                    end
                    r_state <= S_WINDOW;
                end

                S_WINDOW: begin
                    if (r_start > r_eff) begin
                        r_start <= r_now;
                        r_cnt <= '0;
                        r_state <= S_COMMIT;
                    end else if (elapsed >= WINDOW_MIN_US) begin
                        // Launch count * 15625, then shift by 14 for the numerator
                        r_mdu_start <= 1'b1;
                        r_mdu_div <= 1'b0;
                        r_mdu_x <= {{(MDU_XW-32){1'b0}}, r_cnt};
                        r_mdu_y <= {12'd0, RATE_MUL};
                        r_elapsed <= elapsed;
                        r_start <= r_now;
                        r_cnt <= '0;
                        r_state <= S_NUM;
                    end else begin
                        r_state <= S_COMMIT;
                    end
                end

                S_NUM: begin
                    if (mdu_stat.done) begin
                        r_mdu_start <= 1'b1;
                        r_mdu_div <= 1'b1;
                        r_mdu_x <= {mdu_result[MDU_XW-RATE_SHIFT-1:0],
                                    {RATE_SHIFT{1'b0}}};
                        r_mdu_y <= r_elapsed;
                        r_state <= S_DIV;
                    end else begin
                        r_mdu_start <= 1'b0;
                    end
                end

                S_DIV: begin
                    r_mdu_start <= 1'b0;
                    if (mdu_stat.done) begin
                        r_rate <= mdu_stat.sat ? RATE_MAX : mdu_result[15:0];
                        r_rate_upd <= 1'b1;
                        r_state <= S_COMMIT;
                    end
                end

                S_COMMIT: begin
                    if (r_kind == KIND_VI) begin
                        r_vi_count <= r_cnt;
                        r_vi_start <= r_start;
                        r_vi_last <= r_eff;
                        if (r_rate_upd) begin
                            r_vi_rate <= r_rate;
                        end
                    end else begin
                        r_fr_count <= r_cnt;
                        r_fr_start <= r_start;
                        r_fr_last <= r_eff;
                        if (r_rate_upd) begin
                            r_fr_rate <= r_rate;
                        end
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    // Hold until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data <= {4'd0, r_fr_rate, r_vi_rate, r_wait};
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for frame_pacer_rate_meter_core: drives timestamped event
// requests and APB register writes, and predicts every report to check it field by field.
// Depends on fprm_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fprm_pkg::*;

    // Codes the package leaves out
    localparam logic [1:0] KIND_SPARE = 2'd3;   // unused kind, reports rates as held
    localparam logic [1:0] MODE_EVERY = 2'd1;   // pace every interrupt
    localparam logic [1:0] MODE_SPARE = 2'd3;   // undefined mode, paces like mode 1
    localparam logic [63:0] Q8_PER_US = 64'd256_000_000;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [19:0] wait_us;
        logic [15:0] vi_rate_q8;
        logic [15:0] frame_rate_q8;
    } meter_report_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    frame_pacer_rate_meter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),    // [31:0] now_us
        .s_axis_tuser  (s_tuser),    // [1:0] kind
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),    // [19:0] wait_us, [35:20] vi_rate_q8,
                                     // [51:36] frame_rate_q8, [55:52] zero
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predicted register and rate-meter state, mirrored from the spec
    logic [19:0] cfg_period = PERIOD_RESET;
    logic [1:0]  cfg_mode = MODE_RESET;
    logic [31:0] vi_cnt = '0, vi_win = '0, vi_last = '0, vi_waits = '0;
    logic [15:0] vi_rate = '0;
    logic [31:0] fr_cnt = '0, fr_win = '0, fr_last = '0;
    logic [15:0] fr_rate = '0;
    logic        drawn = 1'b0;

    meter_report_t expected_reports[$];
    logic [31:0] stream_time = '0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;
    int reports_seen = 0;
    int mismatches = 0;

    initial forever #5 i_clk = ~i_clk;

    // Hard stop well beyond the slowest legal run
    initial begin
        #(15_000_000);
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED)
            $display("tb: mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Close the rate window once it spans at least half a second; restart it
    // whenever its start lies ahead of the effective time.
    task automatic roll_window(input logic [31:0] eff, input logic [31:0] now,
                               inout logic [31:0] start, inout logic [31:0] count,
                               inout logic [15:0] rate);
        logic [31:0] elapsed;
        logic [63:0] q;
        if (start > eff) begin
            start = now;
            count = '0;
        end else begin
            elapsed = eff - start;
            if (elapsed >= WINDOW_MIN_US) begin
                q = ({32'd0, count} * Q8_PER_US) / {32'd0, elapsed};
                rate = (q > {48'd0, RATE_MAX}) ? RATE_MAX : q[15:0];
                start = now;
                count = '0;
            end
        end
    endtask

    // Advance the predicted meter by one event and build the report it yields
    task automatic advance_meter(input logic [1:0] kind, input logic [31:0] now,
                                 output meter_report_t rep);
        logic [31:0] eff, gap, target, d;
        logic [63:0] bound, prod;
        rep.wait_us = '0;
        case (kind)
            KIND_VI: begin
                eff = now;
                gap = now - vi_last;
                vi_cnt = vi_cnt + 32'd1;
                if (cfg_mode != MODE_OFF) begin
                    if (cfg_mode == MODE_DRAWN && !drawn) begin
                        vi_waits = vi_waits + 32'd1;
                    end else begin
                        bound = {44'd0, cfg_period} * ({32'd0, vi_waits} + 64'd1);
                        if ({32'd0, gap} < bound) begin
                            prod = {44'd0, cfg_period} * {32'd0, vi_cnt};
                            target = vi_win + prod[31:0];
                            d = target - now;
                            if (d >= 32'd1 && d < WAIT_LIMIT_US) rep.wait_us = d[19:0];
                            eff = now + d;
                        end
                        drawn = 1'b0;
                        vi_waits = '0;
                    end
                end
                roll_window(eff, now, vi_win, vi_cnt, vi_rate);
                vi_last = eff;
            end
            KIND_FRAME: begin
                fr_cnt = fr_cnt + 32'd1;
                drawn = 1'b1;
                roll_window(now, now, fr_win, fr_cnt, fr_rate);
                fr_last = now;
            end
            KIND_HK: begin
                if ((now - fr_last) > STALE_US) fr_rate = '0;
                if ((now - vi_last) > STALE_US) vi_rate = '0;
            end
            default: ;
        endcase
        rep.vi_rate_q8 = vi_rate;
        rep.frame_rate_q8 = fr_rate;
    endtask

    // Receiver: stall at the configured rate, re-rolled every cycle
    always @(negedge i_clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Check every accepted report against the oldest prediction
    always @(posedge i_clk) begin
        meter_report_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("report %h with no request pending", m_tdata));
            end else begin
                want = expected_reports.pop_front();
                if (m_tdata[19:0] !== want.wait_us)
                    report_mismatch($sformatf("report %0d wait_us %0d, want %0d",
                                              reports_seen, m_tdata[19:0], want.wait_us));
                if (m_tdata[35:20] !== want.vi_rate_q8)
                    report_mismatch($sformatf("report %0d vi_rate_q8 %h, want %h",
                                              reports_seen, m_tdata[35:20], want.vi_rate_q8));
                if (m_tdata[51:36] !== want.frame_rate_q8)
                    report_mismatch($sformatf("report %0d frame_rate_q8 %h, want %h",
                                              reports_seen, m_tdata[51:36],
                                              want.frame_rate_q8));
                if (m_tdata[55:52] !== 4'd0)
                    report_mismatch($sformatf("report %0d pad bits %h", reports_seen,
                                              m_tdata[55:52]));
                reports_seen++;
            end
        end
    end

    // Send one event request; predict its report once the core takes it
    task automatic send_event(input logic [1:0] kind, input logic [31:0] now);
        meter_report_t rep;
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge i_clk) s_tvalid <= 1'b0;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata <= now;
        s_tuser <= kind;
        do @(posedge i_clk); while (!s_tready);
        advance_meter(kind, now, rep);
        expected_reports.push_back(rep);
        items_sent++;
    endtask

    // Drop valid and hold off until every pending report has come back
    task automatic wait_for_reports;
        @(negedge i_clk) s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register while the core is idle, then read it back
    task automatic cfg_write(input logic idx, input logic [31:0] value);
        logic [31:0] readback, stored;
        wait_for_reports;
        apb_access(1'b1, {idx, 2'b00}, value, readback);
        apb_access(1'b0, {idx, 2'b00}, '0, readback);
        if (idx == REG_PERIOD) begin
            cfg_period = value[19:0];
            stored = {12'd0, value[19:0]};
        end else begin
            cfg_mode = value[1:0];
            stored = {30'd0, value[1:0]};
        end
        if (readback !== stored)
            report_mismatch($sformatf("register %0d reads %h, want %h", idx, readback, stored));
    endtask

    // Mostly a paced interrupt stream with frames and housekeeping, mixed
    // with stale gaps, time jumping back, pure noise and full drains.
    task automatic run_traffic(input int count);
        int stop_at;
        int pick;
        logic [31:0] nominal;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            nominal = (cfg_period == 20'd0) ? 32'd16667 : {12'd0, cfg_period};
            pick = $urandom_range(0, 99);
            if (pick < 1) begin
                wait_for_reports;
            end else if (pick < 5) begin
                stream_time += $urandom_range(1_000_001, 3_000_000);
                send_event(KIND_HK, stream_time);
            end else if (pick < 11) begin
                send_event(2'($urandom_range(0, 3)), $urandom);
            end else if (pick < 14) begin
                stream_time -= $urandom_range(1, 200_000);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    stream_time += nominal - nominal / 8 + $urandom_range(0, nominal / 4);
                else if (pick < 8)
                    stream_time += $urandom_range(0, nominal);
                else
                    stream_time += nominal + $urandom_range(0, 3 * nominal);
                send_event(KIND_VI, stream_time);
                if ($urandom_range(0, 9) < 6)
                    send_event(KIND_FRAME, stream_time + $urandom_range(0, nominal / 2));
                if ($urandom_range(0, 9) == 0)
                    send_event(KIND_HK, stream_time + $urandom_range(0, 2 * nominal));
            end
        end
    endtask

    // Reset defaults: every kind, field extremes, staleness edges, time wrap
    task automatic test_directed_events;
        send_event(KIND_VI, 32'd0);
        send_event(KIND_VI, 32'd16000);
        send_event(KIND_FRAME, 32'd20000);
        send_event(KIND_HK, 32'd30000);
        send_event(KIND_SPARE, 32'hFFFF_FFFF);
        send_event(KIND_FRAME, 32'd520000);
        send_event(KIND_VI, 32'd600000);
        // frame exactly one second old: not yet stale
        send_event(KIND_HK, 32'd1_520_000);
        send_event(KIND_HK, 32'd1_520_001);
        send_event(KIND_HK, 32'd1_600_001);
        send_event(KIND_VI, 32'hFFFF_FFF0);
        send_event(KIND_VI, 32'h0000_0010);
        send_event(KIND_FRAME, 32'd0);
    endtask

    // Pace-after-draw, undefined mode, zero period and the widest period
    task automatic test_pacing_modes;
        cfg_write(REG_MODE, {30'd0, MODE_DRAWN});
        send_event(KIND_VI, 32'd2_000_000);
        send_event(KIND_VI, 32'd2_000_100);
        send_event(KIND_FRAME, 32'd2_005_000);
        send_event(KIND_VI, 32'd2_010_000);
        cfg_write(REG_MODE, {30'd0, MODE_SPARE});
        send_event(KIND_VI, 32'd2_020_000);
        send_event(KIND_VI, 32'd2_021_000);
        cfg_write(REG_PERIOD, 32'd0);
        send_event(KIND_VI, 32'd2_022_000);
        send_event(KIND_VI, 32'd2_022_001);
        cfg_write(REG_PERIOD, 32'h000F_FFFF);
        send_event(KIND_VI, 32'd2_100_000);
        cfg_write(REG_MODE, {30'd0, MODE_OFF});
        send_event(KIND_VI, 32'd2_100_500);
    endtask

    task automatic test_paced_stream;
        cfg_write(REG_PERIOD, 32'd16667);
        cfg_write(REG_MODE, {30'd0, MODE_EVERY});
        stream_time = 32'd5_000_000;
        run_traffic(170);
        cfg_write(REG_PERIOD, 32'd1);
        cfg_write(REG_MODE, {30'd0, MODE_DRAWN});
        run_traffic(170);
    endtask

    // Pile ~140 events into one instant, then close the window half a second
    // later so both rates clip at full scale.
    task automatic test_rate_saturation;
        logic [1:0] kind;
        cfg_write(REG_PERIOD, 32'd1_000_000);
        cfg_write(REG_MODE, {30'd0, MODE_OFF});
        for (int k = 0; k < 2; k++) begin
            kind = (k == 0) ? KIND_FRAME : KIND_VI;
            stream_time += 32'd2_000_000;
            for (int i = 0; i < 140; i++) send_event(kind, stream_time + i);
            stream_time += 32'd500_000 + $urandom_range(0, 1000);
            send_event(kind, stream_time);
        end
        run_traffic(170);
    endtask

    task automatic test_wrap_and_spare_mode;
        cfg_write(REG_PERIOD, 32'h000F_FFFF);
        cfg_write(REG_MODE, {30'd0, MODE_SPARE});
        stream_time = 32'hFFF0_0000;
        run_traffic(170);
    endtask

    // Junk in the upper data bits must be dropped by the registers
    task automatic test_random_settings;
        logic [31:0] value;
        cfg_write(REG_PERIOD, 32'd0);
        cfg_write(REG_MODE, {30'd0, MODE_DRAWN});
        run_traffic(170);
        value = $urandom;
        value[19:0] = 20'($urandom_range(1, 1_000_000));
        cfg_write(REG_PERIOD, value);
        cfg_write(REG_MODE, $urandom);
        run_traffic(170);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Sender mostly busy, receiver stalls heavily
        send_idle_pct = 7;
        recv_idle_pct = 68;
        test_directed_events;
        test_pacing_modes;
        test_paced_stream;

        // Swap: sender starves the core, receiver rarely stalls
        send_idle_pct = 68;
        recv_idle_pct = 7;
        test_rate_saturation;
        test_wrap_and_spare_mode;

        // Full throughput
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_settings;

        wait_for_reports;
        repeat (200) @(posedge i_clk);   // catch any stray report
        $display("tb: %0d event requests, %0d reports checked, %0d mismatches",
                 items_sent, reports_seen, mismatches);
        $display("tb: covered pacing modes 0-3, periods 0/1/16667/1000000/max, stale and wrap");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/fprm_pkg.sv
hw/rtl/fprm_mdu.sv
hw/rtl/frame_pacer_rate_meter_core.sv
verif/testbench.sv
